FILE: src/srp_pkg.sv
`timescale 1ns / 1ps
package srp_pkg;

  localparam int SHELF_COUNT = 64;
  localparam int IDX_W       = $clog2(SHELF_COUNT);
  localparam int CNT_W       = $clog2(SHELF_COUNT + 1);
  localparam int DIM_W       = 15;
  localparam int SUM_W       = DIM_W + 1;
  localparam int SHELF_OUT_W = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 56;

  localparam logic [DIM_W-1:0] COUNT_MAX   = '1;
  localparam logic [DIM_W-1:0] ATLAS_RESET = DIM_W'(1024);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 1'b1;

  typedef enum logic [1:0] {
    ST_EXISTING = 2'd0,
    ST_NEW      = 2'd1,
    ST_NO_ROOM  = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0] used_w;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] count;
  } shelf_t;

  typedef struct packed {
    logic start;
    logic eval;
  } scan_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [DIM_W-1:0] used_w;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] count;
    logic [DIM_W-1:0] pos_y;
    logic [DIM_W-1:0] reserved;
  } scan_result_t;

endpackage

FILE: src/srp_shelf_mem.sv
`timescale 1ns / 1ps
module srp_shelf_mem (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [srp_pkg::IDX_W-1:0] wr_addr_i,
  input  srp_pkg::shelf_t       wr_data_i,
  input  logic                  rd_en_i,
  input  logic [srp_pkg::IDX_W-1:0] rd_addr_i,
  output srp_pkg::shelf_t       rd_data_o
);
  import srp_pkg::*;

  shelf_t mem_q [SHELF_COUNT];
  shelf_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/srp_scan_unit.sv
`timescale 1ns / 1ps
module srp_scan_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  srp_pkg::scan_ctrl_t       ctrl_i,
  input  srp_pkg::shelf_t           shelf_i,
  input  logic [srp_pkg::IDX_W-1:0] shelf_idx_i,
  input  logic [srp_pkg::DIM_W-1:0] atlas_w_i,
  input  logic [srp_pkg::DIM_W-1:0] item_w_i,
  input  logic [srp_pkg::DIM_W-1:0] item_h_i,
  output srp_pkg::scan_result_t     result_o
);
  import srp_pkg::*;

  scan_result_t res_q, res_d;
  logic [SUM_W-1:0] span;
  logic             fits;

  // one shelf per cycle while eval is set, through the shared add and compare
  assign span = {1'b0, item_w_i} + {1'b0, shelf_i.used_w};
  assign fits = (span <= {1'b0, atlas_w_i}) && (item_h_i <= shelf_i.height) &&
                (shelf_i.height > res_q.height);

  always_comb begin
    res_d = res_q;
    if (ctrl_i.start) begin
      res_d = '0;
    end else if (ctrl_i.eval) begin
      if (fits) begin
        res_d.found  = 1'b1;
        res_d.idx    = shelf_idx_i;
        res_d.used_w = shelf_i.used_w;
        res_d.height = shelf_i.height;
        res_d.count  = shelf_i.count;
        res_d.pos_y  = res_q.reserved;
      end
      // each shelf opens only below the atlas height then set, so this sum stays in range
      res_d.reserved = res_q.reserved + shelf_i.height;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

FILE: src/shelf_rectangle_packer.sv
`timescale 1ns / 1ps
// allocate: a read of each open shelf, then the compare of the last one, a drain and a decide;
// the result word is registered out of the decide state, and the next word is taken as that
// result word is taken
// clear: result word ready the cycle after accept, next word taken as it goes out
// the rate is set by the single read port of the shelf table, one shelf a cycle
// reset clears the open shelf count, no table clearing pass; atlas size resets to 1024
module shelf_rectangle_packer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [srp_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // item_width, item_height
  input  logic                           s_axis_tuser,  // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [srp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // shelf_index, slot_index, pos_x, pos_y
  output logic [1:0]                     m_axis_tuser,  // status
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srp_pkg::DIM_W-1:0]      cfg_data_i
);
  import srp_pkg::*;

  state_e state_q, state_d;
  logic [DIM_W-1:0] atlas_w_q, atlas_h_q;
  logic [DIM_W-1:0] item_w_q, item_w_d, item_h_q, item_h_d;
  logic [CNT_W-1:0] open_q, open_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;

  logic             out_vld_q, out_vld_d;
  status_e          out_status_q, out_status_d;
  logic [SHELF_OUT_W-1:0] out_shelf_q, out_shelf_d;
  logic [DIM_W-1:0] out_slot_q, out_slot_d, out_x_q, out_x_d, out_y_q, out_y_d;

  logic             in_acc, out_free;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] wr_addr;
  shelf_t           wr_data, rd_data;
  scan_ctrl_t       scan_ctrl;
  scan_result_t     scan_res;
  logic [SUM_W-1:0] new_top;

  srp_shelf_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  srp_scan_unit u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .shelf_i     (rd_data),
    .shelf_idx_i (rd_idx_q),
    .atlas_w_i   (atlas_w_q),
    .item_w_i    (item_w_q),
    .item_h_i    (item_h_q),
    .result_o    (scan_res)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign new_top       = {1'b0, scan_res.reserved} + {1'b0, item_h_q};

  always_comb begin
    state_d      = state_q;
    item_w_d     = item_w_q;
    item_h_d     = item_h_q;
    open_d       = open_q;
    issue_d      = issue_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = scan_res.idx;
    wr_data      = '0;
    scan_ctrl    = '0;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_shelf_d  = out_shelf_q;
    out_slot_d   = out_slot_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_w_d = s_axis_tdata[DIM_W-1:0];
          item_h_d = s_axis_tdata[2*DIM_W-1:DIM_W];
          if (s_axis_tuser == ACT_CLEAR) begin
            open_d       = '0;
            out_vld_d    = 1'b1;
            out_status_d = ST_CLEARED;
            out_shelf_d  = '0;
            out_slot_d   = '0;
            out_x_d      = '0;
            out_y_d      = '0;
          end else begin
            scan_ctrl.start = 1'b1;
            issue_d         = '0;
            state_d         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read of shelf n overlaps the compare of shelf n-1
        rd_en          = issue_q < open_q;
        scan_ctrl.eval = rd_vld_q;
        rd_vld_d       = rd_en;
        rd_idx_d       = issue_q[IDX_W-1:0];
        if (rd_en) begin
          issue_d = issue_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        out_vld_d   = 1'b1;
        out_shelf_d = '0;
        out_slot_d  = '0;
        out_x_d     = '0;
        out_y_d     = '0;
        state_d     = S_IDLE;
        if (scan_res.found) begin
          wr_en          = 1'b1;
          wr_data.used_w = scan_res.used_w + item_w_q;
          wr_data.height = scan_res.height;
          wr_data.count  = (scan_res.count < COUNT_MAX) ? scan_res.count + DIM_W'(1)
                                                         : scan_res.count;
          out_status_d   = ST_EXISTING;
          out_shelf_d    = SHELF_OUT_W'(scan_res.idx);
          out_slot_d     = scan_res.count;
          out_x_d        = scan_res.used_w;
          out_y_d        = scan_res.pos_y;
        end else if ((open_q < CNT_W'(SHELF_COUNT)) && (item_h_q != '0) &&
                     ({1'b0, atlas_h_q} > new_top)) begin
          wr_en          = 1'b1;
          wr_addr        = open_q[IDX_W-1:0];
          wr_data.used_w = item_w_q;
          wr_data.height = item_h_q;
          wr_data.count  = DIM_W'(1);
          open_d         = open_q + CNT_W'(1);
          out_status_d   = ST_NEW;
          out_shelf_d    = SHELF_OUT_W'(open_q);
          out_y_d        = scan_res.reserved;
        end else begin
          out_status_d = ST_NO_ROOM;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      open_q    <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      open_q    <= open_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_w_q     <= item_w_d;
    item_h_q     <= item_h_d;
    rd_idx_q     <= rd_idx_d;
    out_status_q <= out_status_d;
    out_shelf_q  <= out_shelf_d;
    out_slot_q   <= out_slot_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= ATLAS_RESET;
      atlas_h_q <= ATLAS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATLAS_W: atlas_w_q <= cfg_data_i;
        CFG_ATLAS_H: atlas_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'b0, out_y_q, out_x_q, out_slot_q, out_shelf_q};

endmodule

FILE: src/srp_checker.sv
`timescale 1ns / 1ps
module srp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [srp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser
);
  import srp_pkg::*;

  // an allocate word holds off the input while the shelves are scanned
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_ALLOC) |=> !s_axis_tready)
    else $error("input ready right after an allocate word");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_CLEAR) |=>
      (m_axis_tvalid && m_axis_tuser == ST_CLEARED))
    else $error("clear word gave no cleared result");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_NO_ROOM || m_axis_tuser == ST_CLEARED)) |->
      (m_axis_tdata == '0))
    else $error("no room or cleared result with nonzero fields");

  // a fresh shelf takes the item at its left edge as its first slot
  a_new_shelf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_NEW) |-> (m_axis_tdata[35:6] == '0))
    else $error("new shelf result with nonzero slot or x");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind shelf_rectangle_packer srp_checker u_srp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import srp_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [5:0]       shelf;
    logic [DIM_W-1:0] slot;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
  } placement_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // item_width, item_height
  logic                  s_axis_tuser = 1'b0;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // shelf_index, slot_index, pos_x, pos_y
  logic [1:0]            m_axis_tuser;         // status
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [DIM_W-1:0]      cfg_data_i = '0;

  shelf_rectangle_packer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shelf table as the packer should hold it
  logic [DIM_W-1:0] atlas_w = ATLAS_RESET;
  logic [DIM_W-1:0] atlas_h = ATLAS_RESET;
  logic [DIM_W-1:0] shelf_used_w [SHELF_COUNT];
  logic [DIM_W-1:0] shelf_h      [SHELF_COUNT];
  logic [DIM_W-1:0] shelf_cnt    [SHELF_COUNT];

  placement_t  placements_due[$];
  int unsigned mismatches = 0;
  int unsigned n_existing = 0;
  int unsigned n_new      = 0;
  int unsigned n_no_room  = 0;
  int unsigned n_cleared  = 0;
  int unsigned hold_left  = 0;
  bit          steady     = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d words outstanding", placements_due.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic void wipe_shelves();
    for (int i = 0; i < SHELF_COUNT; i++) begin
      shelf_used_w[i] = '0;
      shelf_h[i]      = '0;
      shelf_cnt[i]    = '0;
    end
  endfunction

  function automatic placement_t place_rect(input logic act, input logic [DIM_W-1:0] w,
                                            input logic [DIM_W-1:0] h);
    placement_t r;
    int reserved;
    int best_h;
    int best_y;
    int best;
    int n_open;
    r        = '0;
    r.status = ST_NO_ROOM;
    reserved = 0;
    best_h   = 0;
    best_y   = 0;
    best     = -1;
    n_open   = 0;
    if (act == ACT_CLEAR) begin
      wipe_shelves();
      r.status = ST_CLEARED;
      return r;
    end
    // tallest fitting shelf wins, lowest index on a tie
    while (n_open < SHELF_COUNT && shelf_h[n_open] != '0) begin
      if (int'(w) <= int'(atlas_w) - int'(shelf_used_w[n_open]) &&
          h <= shelf_h[n_open] && int'(shelf_h[n_open]) > best_h) begin
        best_h = int'(shelf_h[n_open]);
        best   = n_open;
        best_y = reserved;
      end
      reserved += int'(shelf_h[n_open]);
      n_open++;
    end
    if (best >= 0) begin
      r.status = ST_EXISTING;
      r.shelf  = best[5:0];
      r.slot   = shelf_cnt[best];
      r.x      = shelf_used_w[best];
      r.y      = best_y[DIM_W-1:0];
      shelf_used_w[best] = shelf_used_w[best] + w;
      if (shelf_cnt[best] != '1) shelf_cnt[best] = shelf_cnt[best] + DIM_W'(1);
    end else if (n_open < SHELF_COUNT && h != '0 && int'(atlas_h) - reserved > int'(h)) begin
      r.status = ST_NEW;
      r.shelf  = n_open[5:0];
      r.y      = reserved[DIM_W-1:0];
      shelf_used_w[n_open] = w;
      shelf_h[n_open]      = h;
      shelf_cnt[n_open]    = DIM_W'(1);
    end
    return r;
  endfunction

  // result side: check every word
  always @(posedge clk_i) begin
    placement_t got;
    placement_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tuser);
      got.shelf  = m_axis_tdata[5:0];
      got.slot   = m_axis_tdata[20:6];
      got.x      = m_axis_tdata[35:21];
      got.y      = m_axis_tdata[50:36];
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word status %0d shelf %0d slot %0d x %0d y %0d",
                   $realtime, got.status, got.shelf, got.slot, got.x, got.y);
      end else begin
        want = placements_due.pop_front();
        case (want.status)
          ST_EXISTING: n_existing++;
          ST_NEW:      n_new++;
          ST_NO_ROOM:  n_no_room++;
          default:     n_cleared++;
        endcase
        if (got.status !== want.status || got.shelf !== want.shelf ||
            got.slot !== want.slot || got.x !== want.x || got.y !== want.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected status %0d shelf %0d slot %0d x %0d y %0d, got %0d %0d %0d %0d %0d",
                     $realtime, want.status, want.shelf, want.slot, want.x, want.y,
                     got.status, got.shelf, got.slot, got.x, got.y);
        end
      end
    end
  end

  // result ready: random stalls, long holds counted down on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 32);
    end
  end

  task automatic send_word(input logic act, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
    if (!steady && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, h, w};
    do @(posedge clk_i); while (!s_axis_tready);
    placements_due.push_back(place_rect(act, w, h));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_atlas(input logic [DIM_W-1:0] aw, input logic [DIM_W-1:0] ah);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ATLAS_W;
    cfg_data_i  <= aw;
    do @(posedge clk_i); while (!cfg_ready_o);
    atlas_w = aw;
    cfg_index_i <= CFG_ATLAS_H;
    cfg_data_i  <= ah;
    do @(posedge clk_i); while (!cfg_ready_o);
    atlas_h = ah;
    cfg_valid_i <= 1'b0;
  endtask

  // reset geometry: new shelves, tallest pick, ties, zero sizes, height limit
  task automatic run_basic_placement();
    send_word(ACT_ALLOC, 15'd1, 15'd1);
    send_word(ACT_ALLOC, 15'd0, 15'd1);
    send_word(ACT_ALLOC, 15'd5, 15'd0);
    send_word(ACT_CLEAR, 15'h7fff, 15'h7fff);
    send_word(ACT_ALLOC, 15'd3, 15'd0);
    send_word(ACT_ALLOC, 15'd1024, 15'd1023);
    send_word(ACT_ALLOC, 15'd1, 15'd1);
    send_word(ACT_CLEAR, 15'd0, 15'd0);
    send_word(ACT_ALLOC, 15'h7fff, 15'h7fff);
    send_word(ACT_ALLOC, 15'h7fff, 15'd1);
    send_word(ACT_CLEAR, 15'd0, 15'd0);
    send_word(ACT_ALLOC, 15'd10, 15'd5);
    send_word(ACT_ALLOC, 15'd1014, 15'd8);
    send_word(ACT_ALLOC, 15'd10, 15'd3);
    send_word(ACT_CLEAR, 15'd0, 15'd0);
    // two equal shelves with room left: the lower index must win
    send_word(ACT_ALLOC, 15'd1000, 15'd8);
    send_word(ACT_ALLOC, 15'd1000, 15'd8);
    send_word(ACT_ALLOC, 15'd10, 15'd8);
    wait_idle();
  endtask

  // register extremes, including an atlas shrunk under open shelves
  task automatic run_atlas_limits();
    set_atlas(15'd16384, 15'd16384);
    send_word(ACT_CLEAR, 15'd0, 15'd0);
    send_word(ACT_ALLOC, 15'd16384, 15'd1);
    send_word(ACT_ALLOC, 15'd1, 15'd1);
    set_atlas(15'd1, 15'd16384);
    send_word(ACT_ALLOC, 15'd1, 15'd1);
    send_word(ACT_ALLOC, 15'd0, 15'd1);
    set_atlas(15'd1, 15'd1);
    send_word(ACT_ALLOC, 15'd1, 15'd1);
    send_word(ACT_CLEAR, 15'd0, 15'd0);
    send_word(ACT_ALLOC, 15'd1, 15'd1);
    send_word(ACT_ALLOC, 15'd0, 15'd0);
    set_atlas(15'd16384, 15'd1);
    send_word(ACT_ALLOC, 15'd1, 15'd1);
    wait_idle();
  endtask

  // results held off for a long stretch so requests back up at the input
  task automatic run_stall_fill();
    set_atlas(ATLAS_RESET, ATLAS_RESET);
    send_word(ACT_CLEAR, 15'd0, 15'd0);
    hold_left = 400;
    repeat (30) send_word(ACT_ALLOC, 15'($urandom_range(64, 0)), 15'($urandom_range(16, 1)));
    wait_idle();
  endtask

  task automatic run_random_mix(input logic [DIM_W-1:0] aw, input logic [DIM_W-1:0] ah,
                                input int n, input int max_w, input int max_h,
                                input int clear_pct);
    int roll;
    set_atlas(aw, ah);
    send_word(ACT_CLEAR, 15'($urandom), 15'($urandom));
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < clear_pct)
        send_word(ACT_CLEAR, 15'($urandom), 15'($urandom));
      else if (roll < clear_pct + 8)
        send_word(ACT_ALLOC, 15'($urandom), 15'($urandom));
      else
        send_word(ACT_ALLOC, 15'($urandom_range(max_w, 0)), 15'($urandom_range(max_h, 1)));
    end
  endtask

  initial begin
    int aw;
    int ah;
    wipe_shelves();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_basic_placement();
    run_atlas_limits();
    run_stall_fill();
    run_random_mix(15'd1024, 15'd1024, 300, 256, 48, 3);
    // one pixel wide atlas: a shelf takes at most one item of width one, so requests keep opening new shelves
    run_random_mix(15'd1, 15'd16384, 250, 1, 6, 1);
    steady = 1'b1;
    run_random_mix(15'd16384, 15'd16384, 300, 4096, 2048, 4);
    steady = 1'b0;
    repeat (4) begin
      aw = $urandom_range(16384, 1);
      ah = $urandom_range(16384, 1);
      run_random_mix(aw[DIM_W-1:0], ah[DIM_W-1:0], 130, aw / 4 + 1, ah / 16 + 1, 3);
    end
    run_random_mix(15'd16384, 15'd1, 40, 100, 4, 5);
    run_random_mix(15'd1, 15'd1, 40, 2, 3, 5);
    wait_idle();
    repeat (80) @(posedge clk_i);
    $display("checked %0d placements on open shelves, %0d new shelves, %0d refusals, %0d clears",
             n_existing, n_new, n_no_room, n_cleared);
    $display("atlas sizes from 1 to 16384, full shelf table, long output stall included");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching words", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
